>>> rtl/mm4_pkg.sv
`default_nettype none

package mm4_pkg;

  localparam int unsigned ELEM_W        = 32;
  localparam int unsigned PROD_W        = 2 * ELEM_W;
  localparam int unsigned DIM_DEF       = 4;
  localparam int unsigned FRAC_BITS_DEF = 16;

  typedef struct packed {
    logic signed [ELEM_W-1:0] a_element;
    logic signed [ELEM_W-1:0] b_element;
  } mm4_in_t;

  typedef struct packed {
    logic signed [ELEM_W-1:0] c_element;
    logic                     is_last;
    logic                     saturated;
  } mm4_out_t;

  // token that walks the cell chain alongside the partial sum
  typedef struct packed {
    logic valid;
    logic last;
  } mm4_tag_t;

endpackage

`default_nettype wire

>>> rtl/mm4_cell.sv
`default_nettype none

module mm4_cell import mm4_pkg::*; #(
  parameter int unsigned DIM      = DIM_DEF,
  parameter int unsigned ACC_W    = PROD_W + $clog2(DIM_DEF),
  parameter int unsigned CELL_IDX = 0,
  localparam int unsigned IDX_W   = (DIM > 1) ? $clog2(DIM) : 1
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     en_i,
  input  wire logic                     ld_en_i,
  input  wire logic [IDX_W-1:0]         ld_row_i,
  input  wire logic [IDX_W-1:0]         ld_col_i,
  input  wire logic signed [ELEM_W-1:0] ld_a_i,
  input  wire logic signed [ELEM_W-1:0] ld_b_i,
  input  wire mm4_tag_t                 tag_i,
  input  wire logic [IDX_W-1:0]         row_i,
  input  wire logic [IDX_W-1:0]         col_i,
  input  wire logic signed [ACC_W-1:0]  psum_i,
  output      mm4_tag_t                 tag_o,
  output      logic [IDX_W-1:0]         row_o,
  output      logic [IDX_W-1:0]         col_o,
  output      logic signed [ACC_W-1:0]  psum_o,
  output      logic                     busy_o
);

  // column CELL_IDX of A, row CELL_IDX of B
  logic signed [ELEM_W-1:0] a_col_q [DIM];
  logic signed [ELEM_W-1:0] b_row_q [DIM];

  logic signed [ELEM_W-1:0] a_sel, b_sel;
  logic signed [PROD_W-1:0] prod_d, prod_q;
  logic signed [ACC_W-1:0]  psum_p_q, sum_d, sum_q;
  mm4_tag_t                 p_tag_q, s_tag_q;
  logic [IDX_W-1:0]         p_row_q, p_col_q, s_row_q, s_col_q;

  always_ff @(posedge clk_i) begin
    if (ld_en_i && (ld_col_i == IDX_W'(CELL_IDX))) begin
      a_col_q[ld_row_i] <= ld_a_i;
    end
    if (ld_en_i && (ld_row_i == IDX_W'(CELL_IDX))) begin
      b_row_q[ld_col_i] <= ld_b_i;
    end
  end

  assign a_sel  = a_col_q[row_i];
  assign b_sel  = b_row_q[col_i];
  assign prod_d = a_sel * b_sel;
  assign sum_d  = psum_p_q + ACC_W'(prod_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_tag_q <= '0;
      s_tag_q <= '0;
    end else if (en_i) begin
      p_tag_q <= tag_i;
      s_tag_q <= p_tag_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q   <= prod_d;
      psum_p_q <= psum_i;
      p_row_q  <= row_i;
      p_col_q  <= col_i;
      sum_q    <= sum_d;
      s_row_q  <= p_row_q;
      s_col_q  <= p_col_q;
    end
  end

  assign tag_o  = s_tag_q;
  assign row_o  = s_row_q;
  assign col_o  = s_col_q;
  assign psum_o = sum_q;
  assign busy_o = p_tag_q.valid | s_tag_q.valid;

endmodule

`default_nettype wire

>>> rtl/matrix4_multiply_unit.sv
// Fixed-point DIM x DIM matrix product C = A * B, Q16.16 by default.
// Input channel (in_valid_i / in_stall_o / in_data_i): one transaction per
// element pair, A and B at the same column-major index, index 0 first.
// One pair is taken per cycle while loading.
// After the DIM*DIM-th pair the input stalls; the DIM*DIM elements of C
// are issued into a chain of DIM multiply-add cells, one per cycle unless
// the output stalls, in column-major order. Cell k holds column k of A and
// row k of B and adds its product to the running sum handed on by cell k-1.
// Output channel (out_valid_o / out_stall_i / out_data_o): each element of C
// passes the product and sum registers of every cell and then the output
// register; elements follow one per cycle unless the output stalls. is_last
// marks the final element, saturated marks clamped values.
// Input reopens once the cell chain is empty; the next matrix is not loaded
// while the current one is still being issued or drained.
// A stall on the output freezes the whole cell chain; nothing is lost.
// Reset clears the load position and all valid flags; stored elements
// are not cleared, each is written before it is read.
`default_nettype none

module matrix4_multiply_unit import mm4_pkg::*; #(
  parameter int unsigned DIM       = DIM_DEF,
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output      logic     in_stall_o,
  input  wire mm4_in_t  in_data_i,
  output      logic     out_valid_o,
  input  wire logic     out_stall_i,
  output      mm4_out_t out_data_o
);

  localparam int unsigned IDX_W = (DIM > 1) ? $clog2(DIM) : 1;
  localparam int unsigned ACC_W = PROD_W + $clog2(DIM);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DIM - 1);
  localparam logic signed [ELEM_W-1:0] C_MAX = {1'b0, {(ELEM_W-1){1'b1}}};
  localparam logic signed [ELEM_W-1:0] C_MIN = {1'b1, {(ELEM_W-1){1'b0}}};

  logic [IDX_W-1:0] ld_row_q, ld_row_d, ld_col_q, ld_col_d;
  logic [IDX_W-1:0] iss_row_q, iss_row_d, iss_col_q, iss_col_d;
  logic             iss_act_q, iss_act_d;
  logic             in_acc, adv, ld_done, iss_last;
  logic [DIM-1:0]   busy;

  mm4_tag_t                chain_tag  [DIM+1];
  logic [IDX_W-1:0]        chain_row  [DIM+1];
  logic [IDX_W-1:0]        chain_col  [DIM+1];
  logic signed [ACC_W-1:0] chain_psum [DIM+1];

  logic signed [ACC_W-1:0]         shifted;
  logic [ACC_W-ELEM_W:0]           hi_bits;
  logic                            fits;
  mm4_out_t                        out_d, out_q;
  logic                            out_vld_q;

  assign in_stall_o = iss_act_q | (|busy);
  assign in_acc     = in_valid_i & ~in_stall_o;
  assign adv        = ~out_vld_q | ~out_stall_i;
  assign ld_done    = (ld_row_q == IDX_LAST) && (ld_col_q == IDX_LAST);
  assign iss_last   = (iss_row_q == IDX_LAST) && (iss_col_q == IDX_LAST);

  always_comb begin
    ld_row_d  = ld_row_q;
    ld_col_d  = ld_col_q;
    iss_row_d = iss_row_q;
    iss_col_d = iss_col_q;
    iss_act_d = iss_act_q;
    if (in_acc) begin
      if (ld_row_q == IDX_LAST) begin
        ld_row_d = '0;
        ld_col_d = (ld_col_q == IDX_LAST) ? '0 : ld_col_q + 1'b1;
      end else begin
        ld_row_d = ld_row_q + 1'b1;
      end
      if (ld_done) begin
        iss_act_d = 1'b1;
        iss_row_d = '0;
        iss_col_d = '0;
      end
    end
    if (iss_act_q && adv) begin
      if (iss_row_q == IDX_LAST) begin
        iss_row_d = '0;
        iss_col_d = iss_col_q + 1'b1;
      end else begin
        iss_row_d = iss_row_q + 1'b1;
      end
      if (iss_last) begin
        iss_act_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ld_row_q  <= '0;
      ld_col_q  <= '0;
      iss_row_q <= '0;
      iss_col_q <= '0;
      iss_act_q <= 1'b0;
    end else begin
      ld_row_q  <= ld_row_d;
      ld_col_q  <= ld_col_d;
      iss_row_q <= iss_row_d;
      iss_col_q <= iss_col_d;
      iss_act_q <= iss_act_d;
    end
  end

  assign chain_tag[0].valid = iss_act_q;
  assign chain_tag[0].last  = iss_last;
  assign chain_row[0]       = iss_row_q;
  assign chain_col[0]       = iss_col_q;
  assign chain_psum[0]      = '0;

  for (genvar k = 0; k < DIM; k++) begin : g_cell
    mm4_cell #(
      .DIM      (DIM),
      .ACC_W    (ACC_W),
      .CELL_IDX (k)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .en_i     (adv),
      .ld_en_i  (in_acc),
      .ld_row_i (ld_row_q),
      .ld_col_i (ld_col_q),
      .ld_a_i   (in_data_i.a_element),
      .ld_b_i   (in_data_i.b_element),
      .tag_i    (chain_tag[k]),
      .row_i    (chain_row[k]),
      .col_i    (chain_col[k]),
      .psum_i   (chain_psum[k]),
      .tag_o    (chain_tag[k+1]),
      .row_o    (chain_row[k+1]),
      .col_o    (chain_col[k+1]),
      .psum_o   (chain_psum[k+1]),
      .busy_o   (busy[k])
    );
  end

  // floor shift, then clamp to the element range
  assign shifted = chain_psum[DIM] >>> FRAC_BITS;
  assign hi_bits = shifted[ACC_W-1:ELEM_W-1];
  assign fits    = (&hi_bits) | ~(|hi_bits);

  always_comb begin
    out_d.is_last   = chain_tag[DIM].last;
    out_d.saturated = ~fits;
    if (fits) begin
      out_d.c_element = shifted[ELEM_W-1:0];
    end else if (shifted[ACC_W-1]) begin
      out_d.c_element = C_MIN;
    end else begin
      out_d.c_element = C_MAX;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= chain_tag[DIM].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  a_issue_after_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(iss_act_q) |-> $past(in_acc) && $past(ld_done))
    else $error("issue started without a completed load");

  a_load_idle_while_issuing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    iss_act_q |-> (ld_row_q == '0) && (ld_col_q == '0))
    else $error("load position not rewound while issuing");

  a_last_token_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chain_tag[DIM].valid && chain_tag[DIM].last |->
      (chain_row[DIM] == IDX_LAST) && (chain_col[DIM] == IDX_LAST) && !iss_act_q)
    else $error("last token carries wrong index or issue still active");

  a_sat_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_q.saturated |->
      (out_q.c_element == C_MAX) || (out_q.c_element == C_MIN))
    else $error("saturated element not at range limit");

endmodule

`default_nettype wire
